[src/rbsi_pkg.sv]
// Shared constants for the ray/box slab intersection block.
// No dependencies; imported by rbsi_slab_cell and ray_box_slab_intersect_top.
package rbsi_pkg;

	localparam int NUM_AXES  = 3;
	localparam int CFG_IDX_W = 3;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOX_MIN_X = 3'd0,
		REG_BOX_MAX_X = 3'd1,
		REG_BOX_MIN_Y = 3'd2,
		REG_BOX_MAX_Y = 3'd3,
		REG_BOX_MIN_Z = 3'd4,
		REG_BOX_MAX_Z = 3'd5
	} cfg_reg_t;

endpackage

[src/rbsi_slab_cell.sv]
// One slab cell of the chain: plane distances for one axis, folded into the
// running entry/exit pair. Depends on rbsi_pkg.
module rbsi_slab_cell
	import rbsi_pkg::*;
#(
	parameter int DW   = 32,
	parameter int FW   = 16,
	parameter int AXIS = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic [DW-1:0]                bound_lo,
	input  logic [DW-1:0]                bound_hi,
	input  logic                         v_i,
	input  logic [DW-1:0]                entry_i,
	input  logic [DW-1:0]                exit_i,
	input  logic [NUM_AXES-1:0][DW-1:0]  org_i,
	input  logic [NUM_AXES-1:0][DW-1:0]  rcp_i,
	output logic                         v_o,
	output logic [DW-1:0]                entry_o,
	output logic [DW-1:0]                exit_o,
	output logic [NUM_AXES-1:0][DW-1:0]  org_o,
	output logic [NUM_AXES-1:0][DW-1:0]  rcp_o
);

	localparam int PW = 2 * DW + 2;   // exact product width
	localparam int SW = PW - FW;      // width after the fraction shift
	localparam logic [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

	// stage 1: exact differences
	logic                        v_s1, v_s2, v_s3;
	logic signed [DW:0]          dlo_s1, dhi_s1;
	logic [DW-1:0]               rcp_s1;
	logic [DW-1:0]               ent_s1, ext_s1, ent_s2, ext_s2, ent_s3, ext_s3;
	logic [NUM_AXES-1:0][DW-1:0] org_s1, rcp_a_s1, org_s2, rcp_a_s2, org_s3, rcp_a_s3;
	logic signed [PW-1:0]        plo_s2, phi_s2;

	logic signed [DW:0]          rcp_x;
	logic signed [SW-1:0]        sh_lo, sh_hi;
	logic [DW-1:0]               t_lo, t_hi, t_min, t_max;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= v_i;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dlo_s1   <= $signed({bound_lo[DW-1], bound_lo})
				- $signed({org_i[AXIS][DW-1], org_i[AXIS]});
			dhi_s1   <= $signed({bound_hi[DW-1], bound_hi})
				- $signed({org_i[AXIS][DW-1], org_i[AXIS]});
			rcp_s1   <= rcp_i[AXIS];
			ent_s1   <= entry_i;
			ext_s1   <= exit_i;
			org_s1   <= org_i;
			rcp_a_s1 <= rcp_i;
		end
	end

	// stage 2: products
	assign rcp_x = $signed({rcp_s1[DW-1], rcp_s1});

	always_ff @(posedge clk) begin
		if (adv) begin
			plo_s2   <= PW'(dlo_s1 * rcp_x);
			phi_s2   <= PW'(dhi_s1 * rcp_x);
			ent_s2   <= ent_s1;
			ext_s2   <= ext_s1;
			org_s2   <= org_s1;
			rcp_a_s2 <= rcp_a_s1;
		end
	end

	// stage 3: floor shift, saturate, order the pair, fold
	assign sh_lo = SW'(plo_s2 >>> FW);
	assign sh_hi = SW'(phi_s2 >>> FW);

	always_comb begin
		if (sh_lo[SW-1:DW-1] == '0 || sh_lo[SW-1:DW-1] == '1)
			t_lo = sh_lo[DW-1:0];
		else
			t_lo = sh_lo[SW-1] ? VMIN : VMAX;
		if (sh_hi[SW-1:DW-1] == '0 || sh_hi[SW-1:DW-1] == '1)
			t_hi = sh_hi[DW-1:0];
		else
			t_hi = sh_hi[SW-1] ? VMIN : VMAX;
		if ($signed(t_lo) < $signed(t_hi)) begin
			t_min = t_lo;
			t_max = t_hi;
		end else begin
			t_min = t_hi;
			t_max = t_lo;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ent_s3   <= ($signed(t_min) > $signed(ent_s2)) ? t_min : ent_s2;
			ext_s3   <= ($signed(t_max) < $signed(ext_s2)) ? t_max : ext_s2;
			org_s3   <= org_s2;
			rcp_a_s3 <= rcp_a_s2;
		end
	end

	assign v_o     = v_s3;
	assign entry_o = ent_s3;
	assign exit_o  = ext_s3;
	assign org_o   = org_s3;
	assign rcp_o   = rcp_a_s3;

endmodule

[src/ray_box_slab_intersect_top.sv]
// Top level of the ray/box slab intersection block: box registers, chain of
// three slab cells and the result register. Depends on rbsi_pkg, rbsi_slab_cell.
//
// Tests one ray per beat against the box held in six bound registers
// (index 0..5: min x, max x, min y, max y, min z, max z; reset 0; writes to
// indexes 6 and 7 are dropped). All values are signed fixed point,
// DATA_WIDTH bits with FRAC_BITS fraction bits. Per axis the plane distances
// are (bound - origin) * recip, floor-rounded and saturated; entry is the
// largest slab minimum, exit the smallest slab maximum, and hit means
// entry < exit. On a miss entry reads as the largest value and exit as the
// smallest. Rate: one ray per clock while results are claimed. A ray passes
// through three cells of three stages each (difference, multiply,
// saturate-and-fold), then the result register. The whole chain advances
// together: while a finished result sits unclaimed the chain holds and
// in_ready drops; otherwise it flows freely.
// Bound registers should only be written with the chain empty.
module ray_box_slab_intersect_top
	import rbsi_pkg::*;
#(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [DATA_WIDTH-1:0] cfg_data,
	// ray beats
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DATA_WIDTH-1:0] origin_x,
	input  logic [DATA_WIDTH-1:0] origin_y,
	input  logic [DATA_WIDTH-1:0] origin_z,
	input  logic [DATA_WIDTH-1:0] recip_dir_x,
	input  logic [DATA_WIDTH-1:0] recip_dir_y,
	input  logic [DATA_WIDTH-1:0] recip_dir_z,
	// result beats
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  hit,
	output logic [DATA_WIDTH-1:0] entry_distance,
	output logic [DATA_WIDTH-1:0] exit_distance
);

	localparam logic [DATA_WIDTH-1:0] VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	logic [DATA_WIDTH-1:0] box_q [2*NUM_AXES];

	// chain links between the cells
	logic                                   v_c     [NUM_AXES+1];
	logic [DATA_WIDTH-1:0]                  entry_c [NUM_AXES+1];
	logic [DATA_WIDTH-1:0]                  exit_c  [NUM_AXES+1];
	logic [NUM_AXES-1:0][DATA_WIDTH-1:0]    org_c   [NUM_AXES];
	logic [NUM_AXES-1:0][DATA_WIDTH-1:0]    rcp_c   [NUM_AXES];

	logic                  adv;
	logic                  out_valid_q, hit_q;
	logic [DATA_WIDTH-1:0] entry_q, exit_q;
	logic                  fin_hit;

	// box bound registers; unknown indexes fall through untouched
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2*NUM_AXES; i++)
				box_q[i] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BOX_MIN_X: box_q[0] <= cfg_data;
				REG_BOX_MAX_X: box_q[1] <= cfg_data;
				REG_BOX_MIN_Y: box_q[2] <= cfg_data;
				REG_BOX_MAX_Y: box_q[3] <= cfg_data;
				REG_BOX_MIN_Z: box_q[4] <= cfg_data;
				REG_BOX_MAX_Z: box_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole chain moves unless a result is stuck at the output
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	// head of the chain: empty slab fold starts wide open
	assign v_c[0]     = in_valid;
	assign entry_c[0] = VMIN;
	assign exit_c[0]  = VMAX;
	assign org_c[0]   = {origin_z, origin_y, origin_x};
	assign rcp_c[0]   = {recip_dir_z, recip_dir_y, recip_dir_x};

	for (genvar k = 0; k < NUM_AXES; k++) begin : g_slab
		if (k < NUM_AXES - 1) begin : g_mid
			rbsi_slab_cell #(.DW(DATA_WIDTH), .FW(FRAC_BITS), .AXIS(k)) u_slab (
				.clk      (clk),
				.arst_n   (arst_n),
				.adv      (adv),
				.bound_lo (box_q[2*k]),
				.bound_hi (box_q[2*k+1]),
				.v_i      (v_c[k]),
				.entry_i  (entry_c[k]),
				.exit_i   (exit_c[k]),
				.org_i    (org_c[k]),
				.rcp_i    (rcp_c[k]),
				.v_o      (v_c[k+1]),
				.entry_o  (entry_c[k+1]),
				.exit_o   (exit_c[k+1]),
				.org_o    (org_c[k+1]),
				.rcp_o    (rcp_c[k+1])
			);
		end else begin : g_last
			// ray bundle is spent after the last axis
			rbsi_slab_cell #(.DW(DATA_WIDTH), .FW(FRAC_BITS), .AXIS(k)) u_slab (
				.clk      (clk),
				.arst_n   (arst_n),
				.adv      (adv),
				.bound_lo (box_q[2*k]),
				.bound_hi (box_q[2*k+1]),
				.v_i      (v_c[k]),
				.entry_i  (entry_c[k]),
				.exit_i   (exit_c[k]),
				.org_i    (org_c[k]),
				.rcp_i    (rcp_c[k]),
				.v_o      (v_c[k+1]),
				.entry_o  (entry_c[k+1]),
				.exit_o   (exit_c[k+1]),
				.org_o    (),
				.rcp_o    ()
			);
		end
	end

	// hit decision; a touch counts as a miss
	assign fin_hit = $signed(entry_c[NUM_AXES]) < $signed(exit_c[NUM_AXES]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= v_c[NUM_AXES];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q   <= fin_hit;
			entry_q <= fin_hit ? entry_c[NUM_AXES] : VMAX;
			exit_q  <= fin_hit ? exit_c[NUM_AXES] : VMIN;
		end
	end

	assign out_valid      = out_valid_q;
	assign hit            = hit_q;
	assign entry_distance = entry_q;
	assign exit_distance  = exit_q;

	// checks
	a_hit_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> $signed(entry_distance) < $signed(exit_distance))
		else $error("hit with entry not below exit");

	a_miss_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> entry_distance == VMAX && exit_distance == VMIN)
		else $error("miss without extreme distances");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("ray taken while result stalled");

endmodule
